@@ rtl/core/mfba_pkg.sv @@
// Package for the max-flow block: payload types, sequencer states and register indexes.
package mfba_pkg;

   localparam int NODE_W   = 6;
   localparam int NODE_NUM = 64;
   localparam int FLOW_W   = 24;
   localparam int AUG_W    = 16;
   localparam int CAPIN_W  = 16;
   localparam int CNT_W    = 7;
   localparam int CSR_AW   = 4;
   localparam logic [FLOW_W-1:0] FLOW_MAX = 24'hFFFFFF;
   localparam logic [AUG_W-1:0]  AUG_MAX  = 16'hFFFF;

   localparam logic [1:0] REG_NODE_COUNT = 2'd0;
   localparam logic [1:0] REG_SOURCE     = 2'd1;
   localparam logic [1:0] REG_SINK       = 2'd2;

   typedef struct packed {
      logic [NODE_W-1:0]  edge_from;
      logic [NODE_W-1:0]  edge_to;
      logic [CAPIN_W-1:0] edge_capacity;
      logic               last_edge;
   } req_type;

   typedef struct packed {
      logic [FLOW_W-1:0] total_flow;
      logic [AUG_W-1:0]  augment_count;
      logic              edge_overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_SINIT,
      ST_DEQ,
      ST_DEQ_WAIT,
      ST_SCAN_RD,
      ST_SCAN_FWD,
      ST_SCAN_REV,
      ST_A1,
      ST_A1W,
      ST_A1E,
      ST_A2,
      ST_A2W,
      ST_A2E,
      ST_FINISH
   } state_type;

endpackage

@@ rtl/core/mfba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mfba_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/max_flow_bfs_augment.sv @@
// Top level of the max-flow block: edge loading, breadth-first search and augmentation.
//
// Usage. Edges arrive as items on the req_ channel (valid/ready), one per cycle
// while the block is loading. Each edge is stored as one row of the edge RAM that
// holds both the forward and the reverse residual. The item flagged last_edge
// starts the max-flow run; req_ready stays low until the result has been loaded
// into the output register. A run repeats a breadth-first search, which sweeps
// every stored row once for each node taken from the queue (each row is read, then
// scanned both ways), then walks the found path twice: once for the bottleneck and
// once to update residuals. One result item then appears on the rsp_ channel with
// total flow, augment count and the overflow flag. The result waits in its
// register while the receiver stalls; a later run that finishes holds in its final
// state until it is taken. Edges beyond MAX_EDGES are dropped and flagged. The
// user must write configuration (node count, source, sink) over the APB-style
// port only while the block is idle; the block does not enforce this. Reset is
// synchronous: it empties the edge store, clears the result and loads the
// register defaults (64 nodes, source 0, sink 5). No clearing pass is needed.
module max_flow_bfs_augment
   import mfba_pkg::*;
#(
   parameter int MAX_EDGES = 256,
   parameter int CAP_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // Row index width, entry index width (row plus direction bit), fill count width.
   localparam int PW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EIW = PW + 1;
   localparam int UW  = $clog2(MAX_EDGES + 1);
   localparam int EW  = 2 * NODE_W + 2 * CAP_WIDTH;
   localparam int QAW = $clog2(NODE_NUM);
   localparam int SW  = 33;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]     node_count_ff;
   logic [NODE_W-1:0]    source_ff, sink_ff;
   logic [UW-1:0]        used_ff, used_in;
   logic                 ovf_ff, ovf_in;
   logic [NODE_NUM-1:0]  vis_ff, vis_in;
   logic [CNT_W-1:0]     qhead_ff, qhead_in, qtail_ff, qtail_in;
   logic [NODE_W-1:0]    u_ff, u_in, v_ff, v_in;
   logic [UW-1:0]        scan_ff, scan_in;
   logic [CNT_W-1:0]     steps_ff, steps_in;
   logic [EIW-1:0]       e_ff, e_in;
   logic [CAP_WIDTH-1:0] neck_ff, neck_in;
   logic [FLOW_W-1:0]    total_ff, total_in;
   logic [AUG_W-1:0]     count_ff, count_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Edge RAM ports.
   logic          ed_we, ed_re;
   logic [PW-1:0] ed_waddr, ed_raddr;
   logic [EW-1:0] ed_wdata, ed_rdata;
   // Parent RAM ports.
   logic           pa_we, pa_re;
   logic [QAW-1:0] pa_waddr, pa_raddr;
   logic [EIW-1:0] pa_wdata, pa_rdata;
   // Queue RAM ports.
   logic              q_we, q_re;
   logic [QAW-1:0]    q_waddr, q_raddr;
   logic [NODE_W-1:0] q_wdata, q_rdata;

   mfba_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES), .ADDR_W(PW)) u_edge_ram (
      .clock(clock), .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata),
      .re(ed_re), .raddr(ed_raddr), .rdata(ed_rdata)
   );

   mfba_ram #(.WIDTH(EIW), .DEPTH(NODE_NUM), .ADDR_W(QAW)) u_parent_ram (
      .clock(clock), .we(pa_we), .waddr(pa_waddr), .wdata(pa_wdata),
      .re(pa_re), .raddr(pa_raddr), .rdata(pa_rdata)
   );

   mfba_ram #(.WIDTH(NODE_W), .DEPTH(NODE_NUM), .ADDR_W(QAW)) u_queue_ram (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
   );

   // Effective node count: zero acts as one, and the count never exceeds the node limit.
   logic [CNT_W-1:0] n_eff;
   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (int'(node_count_ff) > NODE_NUM) begin
         n_eff = CNT_W'(NODE_NUM);
      end else begin
         n_eff = node_count_ff;
      end
   end

   // Fields of the row last read from the edge RAM.
   logic [NODE_W-1:0]    row_from, row_to;
   logic [CAP_WIDTH-1:0] row_fwd, row_rev;
   assign row_from = ed_rdata[EW-1 -: NODE_W];
   assign row_to   = ed_rdata[EW-NODE_W-1 -: NODE_W];
   assign row_fwd  = ed_rdata[2*CAP_WIDTH-1:CAP_WIDTH];
   assign row_rev  = ed_rdata[CAP_WIDTH-1:0];

   // Entry view of the row: the reverse entry swaps the endpoints.
   logic                 ent_dir;
   logic [NODE_W-1:0]    ent_tail, ent_head;
   logic [CAP_WIDTH-1:0] ent_res;
   logic                 take;
   always_comb begin
      if (state_ff == ST_SCAN_FWD || state_ff == ST_SCAN_REV) begin
         ent_dir = (state_ff == ST_SCAN_REV);
      end else begin
         ent_dir = e_ff[0];
      end
      ent_tail = ent_dir ? row_to : row_from;
      ent_head = ent_dir ? row_from : row_to;
      ent_res  = ent_dir ? row_rev : row_fwd;
      // A scanned entry is taken when it leaves the current node toward a new node
      // inside the node range, has residual left, and the queue has room.
      take = (ent_tail == u_ff) && ({1'b0, ent_tail} < n_eff) && ({1'b0, ent_head} < n_eff)
             && !vis_ff[ent_head] && (ent_res != '0) && (qtail_ff < n_eff);
   end

   logic req_acc;
   assign req_acc = req_valid && req_ready;

   logic [SW-1:0] flow_sum;
   assign flow_sum = SW'(total_ff) + SW'(neck_ff);

   logic path_open;
   assign path_open = (v_ff != source_ff) && (steps_ff < n_eff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_data.last_edge) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if ({1'b0, source_ff} >= n_eff || {1'b0, sink_ff} >= n_eff
                || source_ff == sink_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SINIT;
            end
         end
         ST_SINIT: state_in = ST_DEQ;
         ST_DEQ: begin
            priority if (vis_ff[sink_ff]) begin
               state_in = ST_A1;
            end else if (qhead_ff < qtail_ff) begin
               state_in = ST_DEQ_WAIT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DEQ_WAIT: state_in = (used_ff == '0) ? ST_DEQ : ST_SCAN_RD;
         ST_SCAN_RD:  state_in = ST_SCAN_FWD;
         ST_SCAN_FWD: state_in = ST_SCAN_REV;
         ST_SCAN_REV: state_in = (scan_ff + UW'(1) == used_ff) ? ST_DEQ : ST_SCAN_RD;
         ST_A1:       state_in = path_open ? ST_A1W : ST_A2;
         ST_A1W:      state_in = ST_A1E;
         ST_A1E:      state_in = ST_A1;
         ST_A2:       state_in = path_open ? ST_A2W : ST_SINIT;
         ST_A2W:      state_in = ST_A2E;
         ST_A2E:      state_in = ST_A2;
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      used_in      = used_ff;
      ovf_in       = ovf_ff;
      vis_in       = vis_ff;
      qhead_in     = qhead_ff;
      qtail_in     = qtail_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      scan_in      = scan_ff;
      steps_in     = steps_ff;
      e_in         = e_ff;
      neck_in      = neck_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == ST_IDLE);

      ed_we    = 1'b0;
      ed_waddr = used_ff[PW-1:0];
      ed_wdata = {req_data.edge_from, req_data.edge_to,
                  CAP_WIDTH'(req_data.edge_capacity), CAP_WIDTH'(0)};
      ed_re    = 1'b0;
      ed_raddr = scan_ff[PW-1:0];
      pa_we    = 1'b0;
      pa_waddr = ent_head[QAW-1:0];
      pa_wdata = {scan_ff[PW-1:0], ent_dir};
      pa_re    = 1'b0;
      pa_raddr = v_ff[QAW-1:0];
      q_we     = 1'b0;
      q_waddr  = qtail_ff[QAW-1:0];
      q_wdata  = ent_head;
      q_re     = 1'b0;
      q_raddr  = qhead_ff[QAW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (int'(used_ff) < MAX_EDGES) begin
                  ed_we   = 1'b1;
                  used_in = used_ff + UW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_START: begin
            total_in = '0;
            count_in = '0;
         end
         ST_SINIT: begin
            vis_in            = '0;
            vis_in[source_ff] = 1'b1;
            q_we              = 1'b1;
            q_waddr           = '0;
            q_wdata           = source_ff;
            qhead_in          = '0;
            qtail_in          = CNT_W'(1);
         end
         ST_DEQ: begin
            if (vis_ff[sink_ff]) begin
               v_in     = sink_ff;
               steps_in = '0;
               neck_in  = '1;
            end else if (qhead_ff < qtail_ff) begin
               q_re     = 1'b1;
               qhead_in = qhead_ff + CNT_W'(1);
            end
         end
         ST_DEQ_WAIT: begin
            u_in    = q_rdata;
            scan_in = '0;
         end
         ST_SCAN_RD: ed_re = 1'b1;
         ST_SCAN_FWD, ST_SCAN_REV: begin
            if (take) begin
               vis_in[ent_head] = 1'b1;
               pa_we            = 1'b1;
               q_we             = 1'b1;
               qtail_in         = qtail_ff + CNT_W'(1);
            end
            if (state_ff == ST_SCAN_REV) begin
               scan_in = scan_ff + UW'(1);
            end
         end
         ST_A1, ST_A2: begin
            if (path_open) begin
               pa_re = 1'b1;
            end else if (state_ff == ST_A1) begin
               v_in     = sink_ff;
               steps_in = '0;
            end else begin
               total_in = (flow_sum > SW'(FLOW_MAX)) ? FLOW_MAX : flow_sum[FLOW_W-1:0];
               count_in = (count_ff == AUG_MAX) ? count_ff : count_ff + AUG_W'(1);
            end
         end
         ST_A1W, ST_A2W: begin
            e_in     = pa_rdata;
            ed_re    = 1'b1;
            ed_raddr = pa_rdata[EIW-1:1];
         end
         ST_A1E: begin
            if (ent_res < neck_ff) begin
               neck_in = ent_res;
            end
            v_in     = ent_tail;
            steps_in = steps_ff + CNT_W'(1);
         end
         ST_A2E: begin
            ed_we    = 1'b1;
            ed_waddr = e_ff[EIW-1:1];
            if (e_ff[0]) begin
               ed_wdata = {row_from, row_to, row_fwd + neck_ff, row_rev - neck_ff};
            end else begin
               ed_wdata = {row_from, row_to, row_fwd - neck_ff, row_rev + neck_ff};
            end
            v_in     = ent_tail;
            steps_in = steps_ff + CNT_W'(1);
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.total_flow    = total_ff;
               rsp_in.augment_count = count_ff;
               rsp_in.edge_overflow = ovf_ff;
               rsp_valid_in         = 1'b1;
               used_in              = '0;
               ovf_in               = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Configuration port: writes complete in the access phase, reads return the value.
   logic csr_wr;
   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_comb begin
      unique case (paddr[3:2])
         REG_NODE_COUNT: prdata = 32'(node_count_ff);
         REG_SOURCE:     prdata = 32'(source_ff);
         REG_SINK:       prdata = 32'(sink_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= CNT_W'(64);
         source_ff     <= '0;
         sink_ff       <= NODE_W'(5);
         used_ff       <= '0;
         ovf_ff        <= 1'b0;
         vis_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         ovf_ff       <= ovf_in;
         vis_ff       <= vis_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            unique case (paddr[3:2])
               REG_NODE_COUNT: node_count_ff <= pwdata[CNT_W-1:0];
               REG_SOURCE:     source_ff     <= pwdata[NODE_W-1:0];
               REG_SINK:       sink_ff       <= pwdata[NODE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      qhead_ff <= qhead_in;
      qtail_ff <= qtail_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      scan_ff  <= scan_in;
      steps_ff <= steps_in;
      e_ff     <= e_in;
      neck_ff  <= neck_in;
      total_ff <= total_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result appears only out of the final state of a run.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result raised outside the final state");

   // The fill count never passes the store depth.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      int'(used_ff) <= MAX_EDGES)
      else $error("edge fill count beyond store depth");

   // Every entry on a found path had residual left, so the bottleneck is nonzero.
   a_neck_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_A2E |-> neck_ff != '0)
      else $error("zero bottleneck during augmentation");

   // The queue read pointer never runs past the write pointer while dequeuing.
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DEQ_WAIT |-> qhead_ff <= qtail_ff)
      else $error("search queue read past its tail");

endmodule
